### sv/bvs_pkg.sv
// Shared types and constants for the bounded version store.
package bvs_pkg;

  localparam int VERSION_W = 32;
  localparam int DATA_W    = 64;
  localparam int SIZE_W    = 16;
  localparam int COUNT_W   = 7;

  // Command codes carried by the mode field.
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_GET = 1'b1;

  typedef struct packed {
    logic signed [VERSION_W-1:0] version;
    logic [DATA_W-1:0]           data;
    logic [SIZE_W-1:0]           size;
  } entry_t;

  // Status that one cell hands to its neighbour further down the row.
  typedef struct packed {
    logic valid;
    logic below;   // valid and stored version is at or below the key
  } nbr_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic compare;
    logic apply_add;
    logic drop;
  } cell_ctrl_t;

endpackage

### sv/bvs_cell.sv
// One slot of the sorted version row, with its compare and shift logic.
module bvs_cell
  import bvs_pkg::*;
#(
  parameter bit IS_LAST = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cell_ctrl_t                  ctrl,
  input  logic signed [VERSION_W-1:0] key,
  input  entry_t                      new_entry,
  input  entry_t                      prev_entry,
  input  nbr_t                        prev_stat,
  input  logic                        any_eq,
  output entry_t                      entry,
  output nbr_t                        stat,
  output logic                        eq
);

  logic valid_eff;
  logic load_new;
  logic load_prev;

  assign valid_eff = stat.valid & ~(ctrl.drop & IS_LAST);

  // The first slot at or below the new version, or else the first empty slot, takes the
  // new word; slots after it take their neighbour's word unless the version was present.
  assign load_new  = (stat.below & ~prev_stat.below) |
                     (~stat.valid & prev_stat.valid & ~prev_stat.below);
  assign load_prev = prev_stat.below & prev_stat.valid & ~any_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      eq   <= 1'b0;
    end else if (ctrl.compare) begin
      stat.valid <= valid_eff;
      stat.below <= valid_eff & (entry.version <= key);
      eq         <= valid_eff & (entry.version == key);
    end else if (ctrl.apply_add) begin
      if (load_new || load_prev) begin
        stat.valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply_add) begin
      if (load_new) begin
        entry <= new_entry;
      end else if (load_prev) begin
        entry <= prev_entry;
      end
    end
  end

endmodule

### sv/bounded_version_store_top.sv
// Bounded version store: a row of slots kept sorted by version, newest first.
// An accepted command word gives its result word, marked by done, after the apply state.
// busy is high in the compare and apply states, so no command is taken until the last
// is through: compare the key in every slot, then shift or select and register.
// Reset empties the store (count zero, all slots invalid); results cannot be stalled.
module bounded_version_store_top
  import bvs_pkg::*;
#(
  parameter int MAX_VERSIONS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic signed [VERSION_W-1:0] version,
  input  logic [DATA_W-1:0]           value_data,
  input  logic [SIZE_W-1:0]           value_size,
  output logic                        done,
  output logic                        found,
  output logic signed [VERSION_W-1:0] found_version,
  output logic [DATA_W-1:0]           found_data,
  output logic [SIZE_W-1:0]           found_size,
  output logic [COUNT_W-1:0]          entry_count
);

  localparam int CNT_W = $clog2(MAX_VERSIONS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t                      state;
  logic                        op_mode;
  logic signed [VERSION_W-1:0] key;
  entry_t                      new_entry;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;

  cell_ctrl_t                  ctrl;
  entry_t                      entries [MAX_VERSIONS];
  nbr_t                        stats   [MAX_VERSIONS];
  logic [MAX_VERSIONS-1:0]     eqs;
  logic                        any_eq;
  logic                        hit_any;
  entry_t                      hit_entry;

  assign busy = (state != S_IDLE);

  assign ctrl.compare   = (state == S_CMP);
  assign ctrl.apply_add = (state == S_APPLY) && (op_mode == MODE_ADD);
  assign ctrl.drop      = (state == S_CMP) && (op_mode == MODE_ADD) &&
                          (count == CNT_W'(MAX_VERSIONS));

  assign any_eq = |eqs;

  for (genvar j = 0; j < MAX_VERSIONS; j++) begin : g_cell
    entry_t prev_entry;
    nbr_t   prev_stat;

    if (j == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_stat  = '{valid: 1'b1, below: 1'b0};
    end else begin : g_body
      assign prev_entry = entries[j-1];
      assign prev_stat  = stats[j-1];
    end

    bvs_cell #(
      .IS_LAST(j == MAX_VERSIONS - 1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .key       (key),
      .new_entry (new_entry),
      .prev_entry(prev_entry),
      .prev_stat (prev_stat),
      .any_eq    (any_eq),
      .entry     (entries[j]),
      .stat      (stats[j]),
      .eq        (eqs[j])
    );
  end

  // The row is sorted, so the newest slot at or below the key is the first
  // one whose flag is set: at most one slot sees its flag rise.
  always_comb begin
    hit_any   = 1'b0;
    hit_entry = '0;
    for (int j = 0; j < MAX_VERSIONS; j++) begin
      if (stats[j].below && (j == 0 || !stats[(j == 0) ? 0 : j-1].below)) begin
        hit_entry = hit_entry | entries[j];
      end
      hit_any = hit_any | stats[j].below;
    end
  end

  always_comb begin
    count_next = count;
    if (op_mode == MODE_ADD && !any_eq) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (ctrl.drop) begin
            count <= count - CNT_W'(1);
          end
          state <= S_APPLY;
        end
        S_APPLY: begin
          count <= count_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_mode           <= mode;
      key               <= version;
      new_entry.version <= version;
      new_entry.data    <= value_data;
      new_entry.size    <= value_size;
    end
    if (state == S_APPLY) begin
      entry_count <= COUNT_W'(count_next);
      if (op_mode == MODE_ADD || !hit_any) begin
        found         <= 1'b0;
        found_version <= '0;
        found_data    <= '0;
        found_size    <= '0;
      end else begin
        found         <= 1'b1;
        found_version <= hit_entry.version;
        found_data    <= hit_entry.data;
        found_size    <= hit_entry.size;
      end
    end
  end

endmodule

### test/bounded_version_store_top_tb.sv
// Self-checking testbench for the bounded version store: directed and random command words.
module bounded_version_store_top_tb
  import bvs_pkg::*;
();

  localparam int STORE_DEPTH   = 8;
  localparam int RANDOM_WORDS  = 850;
  localparam int CALM_TAIL     = 120;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LIMIT  = 10;

  localparam logic signed [VERSION_W-1:0] VERSION_MIN = 32'h8000_0000;
  localparam logic signed [VERSION_W-1:0] VERSION_MAX = 32'h7fff_ffff;

  typedef struct {
    logic                        mode;
    logic signed [VERSION_W-1:0] version;
    logic [DATA_W-1:0]           data;
    logic [SIZE_W-1:0]           size;
    bit                          drain_first;
  } command_t;

  typedef struct {
    logic                        found;
    logic signed [VERSION_W-1:0] version;
    logic [DATA_W-1:0]           data;
    logic [SIZE_W-1:0]           size;
    logic [COUNT_W-1:0]          count;
  } answer_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        mode = MODE_ADD;
  logic signed [VERSION_W-1:0] version = '0;
  logic [DATA_W-1:0]           value_data = '0;
  logic [SIZE_W-1:0]           value_size = '0;
  logic                        busy;
  logic                        done;
  logic                        found;
  logic signed [VERSION_W-1:0] found_version;
  logic [DATA_W-1:0]           found_data;
  logic [SIZE_W-1:0]           found_size;
  logic [COUNT_W-1:0]          entry_count;

  bounded_version_store_top #(
    .MAX_VERSIONS(STORE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .version(version),
    .value_data(value_data),
    .value_size(value_size),
    .done(done),
    .found(found),
    .found_version(found_version),
    .found_data(found_data),
    .found_size(found_size),
    .entry_count(entry_count)
  );

  always #5 clk = ~clk;

  command_t command_q[$];
  answer_t  answer_q[$];
  command_t cur_cmd;
  bit       word_taken = 1'b0;
  int       idle_left = 0;
  int       issued_n = 0;
  int       accepted_n = 0;
  int       total_n = 0;
  int       stall_n = 0;
  int       error_n = 0;

  // Shadow copy of the store, newest version in slot 0.
  logic signed [VERSION_W-1:0] shadow_version [STORE_DEPTH];
  logic [DATA_W-1:0]           shadow_data [STORE_DEPTH];
  logic [SIZE_W-1:0]           shadow_size [STORE_DEPTH];
  int                          shadow_count = 0;

  function automatic answer_t predict_access(command_t c);
    answer_t                     a;
    logic signed [VERSION_W-1:0] key;
    int                          n;
    bit                          placed;
    a = '{default: '0};
    key = c.version;
    if (c.mode == MODE_ADD) begin
      // A full store loses its oldest entry before anything else happens.
      n = (shadow_count >= STORE_DEPTH) ? STORE_DEPTH - 1 : shadow_count;
      placed = 1'b0;
      for (int i = 0; i < n && !placed; i++) begin
        if (key > shadow_version[i]) begin
          for (int j = n; j > i; j--) begin
            shadow_version[j] = shadow_version[j-1];
            shadow_data[j]    = shadow_data[j-1];
            shadow_size[j]    = shadow_size[j-1];
          end
          shadow_version[i] = key;
          shadow_data[i]    = c.data;
          shadow_size[i]    = c.size;
          n++;
          placed = 1'b1;
        end else if (key == shadow_version[i]) begin
          shadow_data[i] = c.data;
          shadow_size[i] = c.size;
          placed = 1'b1;
        end
      end
      if (!placed) begin
        shadow_version[n] = key;
        shadow_data[n]    = c.data;
        shadow_size[n]    = c.size;
        n++;
      end
      shadow_count = n;
    end else begin
      for (int i = 0; i < shadow_count && !a.found; i++) begin
        if (shadow_version[i] <= key) begin
          a.found   = 1'b1;
          a.version = shadow_version[i];
          a.data    = shadow_data[i];
          a.size    = shadow_size[i];
        end
      end
    end
    a.count = COUNT_W'(shadow_count);
    return a;
  endfunction

  task automatic queue_command(input logic m, input logic signed [VERSION_W-1:0] v,
                               input logic [DATA_W-1:0] d, input int s,
                               input bit drain);
    command_t c;
    c.mode        = m;
    c.version     = v;
    c.data        = d;
    c.size        = SIZE_W'(s);
    c.drain_first = drain;
    command_q.push_back(c);
  endtask

  // Driver: a new word goes out once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst && (!start || word_taken)) begin
      if (idle_left == 0 && issued_n < total_n - CALM_TAIL && $urandom_range(0, 5) == 0)
        idle_left = $urandom_range(1, 11);
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (command_q.size() != 0 &&
                   !(command_q[0].drain_first && answer_q.size() != 0)) begin
        cur_cmd = command_q.pop_front();
        mode       <= cur_cmd.mode;
        version    <= cur_cmd.version;
        value_data <= cur_cmd.data;
        value_size <= cur_cmd.size;
        start      <= 1'b1;
        issued_n++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks result words, predicts accepted command words, guards against hangs.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      word_taken = 1'b0;
      stall_n = 0;
    end else begin
      word_taken = start && !busy;
      if (done) begin
        if (answer_q.size() == 0) begin
          error_n++;
          if (error_n <= REPORT_LIMIT)
            $display("unexpected result word: found %0b version %0d count %0d",
                     found, found_version, entry_count);
        end else begin
          want = answer_q.pop_front();
          if (found !== want.found || found_version !== want.version ||
              found_data !== want.data || found_size !== want.size ||
              entry_count !== want.count) begin
            error_n++;
            if (error_n <= REPORT_LIMIT)
              $display({"result mismatch (expected/actual): found %0b/%0b version %0d/%0d",
                        " data %h/%h size %0d/%0d count %0d/%0d"},
                       want.found, found, want.version, found_version, want.data,
                       found_data, want.size, found_size, want.count, entry_count);
          end
        end
      end
      if (word_taken) begin
        answer_q.push_back(predict_access(cur_cmd));
        accepted_n++;
      end
      if (done || word_taken) begin
        stall_n = 0;
      end else begin
        stall_n++;
        if (stall_n >= STALL_LIMIT) begin
          $display("bounded_version_store_top_tb: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    logic signed [VERSION_W-1:0] base;
    logic signed [VERSION_W-1:0] v;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lookups on an empty store, then the extremes of every field.
    queue_command(MODE_GET, 0, '0, '0, 1'b0);
    queue_command(MODE_GET, VERSION_MIN, '1, '1, 1'b0);
    queue_command(MODE_ADD, 0, '1, '1, 1'b0);
    queue_command(MODE_ADD, VERSION_MAX, '0, '0, 1'b0);
    queue_command(MODE_ADD, VERSION_MIN, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    queue_command(MODE_ADD, 0, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    queue_command(MODE_GET, VERSION_MAX, '0, '0, 1'b0);
    queue_command(MODE_GET, VERSION_MIN, '0, '0, 1'b0);
    queue_command(MODE_GET, -1, '0, '0, 1'b0);
    queue_command(MODE_GET, 5, '0, '0, 1'b0);
    for (int k = 1; k <= 5; k++)
      queue_command(MODE_ADD, 10 * k, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    // The store is full now: a version below all but the oldest entry, then a version already held.
    queue_command(MODE_ADD, -5, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    queue_command(MODE_ADD, 20, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    queue_command(MODE_ADD, -7, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    // The held version is the oldest, so it is dropped and then added afresh.
    queue_command(MODE_ADD, -7, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    queue_command(MODE_ADD, VERSION_MAX, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    queue_command(MODE_ADD, 25, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    queue_command(MODE_ADD, 60, {$urandom, $urandom}, $urandom_range(0, 65535), 1'b0);
    queue_command(MODE_GET, VERSION_MIN, '0, '0, 1'b0);
    queue_command(MODE_GET, 35, '0, '0, 1'b0);

    // Mostly versions from a narrow window, so that inserts, overwrites and misses all occur.
    base = $urandom;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: base = $urandom;
          1: base = -8;
          2: base = 32'h7fff_fff0;
          default: base = VERSION_MIN;
        endcase
      end
      case ($urandom_range(0, 9))
        0: v = $urandom;
        1: begin
          case ($urandom_range(0, 3))
            0: v = VERSION_MIN;
            1: v = VERSION_MAX;
            2: v = VERSION_MIN + 1;
            default: v = VERSION_MAX - 1;
          endcase
        end
        default: v = base + $urandom_range(0, 17) - 2;
      endcase
      queue_command($urandom_range(0, 1) ? MODE_GET : MODE_ADD, v, {$urandom, $urandom},
                    $urandom_range(0, 65535), k % 200 == 0);
    end
    total_n = command_q.size();

    wait (accepted_n == total_n && answer_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_n == 0 && answer_q.size() == 0) begin
      $display("bounded_version_store_top_tb: done, clean");
    end else begin
      $display("bounded_version_store_top_tb: done, errors");
    end
    $finish;
  end

endmodule
